/* src/sgpa_pkg.sv */
package sgpa_pkg;

  // reset values of the configuration registers
  localparam logic [31:0] GravityReset = 32'd65536;
  localparam logic [31:0] MinDistReset = 32'd52429;

  // pipeline geometry
  localparam int unsigned RadW     = 67;   // sum of two squared 33-bit magnitudes
  localparam int unsigned RootW    = 35;   // square root bits, one per stage
  localparam int unsigned NumW     = 113;  // G*m*|r_c| scaled by 2^16
  localparam int unsigned CubeW    = 105;  // d^3 with d of RootW bits
  localparam int unsigned QuotW    = 33;   // quotient bits, one per stage
  localparam int unsigned SqrtLat  = RootW;
  localparam int unsigned DivLat   = QuotW + 1;

  // configuration register indexes
  typedef enum logic [1:0] {
    RegGravity = 2'd0,
    RegMinDist = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] source_x;
    logic signed [31:0] source_y;
    logic        [31:0] source_mass;
  } in_t;

  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic               saturated;
  } out_t;

endpackage

/* src/sgpa_isqrt.sv */
module sgpa_isqrt
  import sgpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RadW-1:0]   rad_i,
  output logic [RootW-1:0]  root_o
);

  localparam int unsigned TrialW = 2 * RootW + 2;

  logic [RootW-1:0] root_q [RootW];
  logic [RadW-1:0]  rem_q  [RootW-1];

  // one root bit per stage, most significant first
  for (genvar k = 0; k < RootW; k++) begin : g_stage
    localparam int unsigned B = RootW - 1 - k;
    logic [RadW-1:0]   rem_in;
    logic [RootW-1:0]  root_in;
    logic [TrialW-1:0] trial;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b)
    assign trial = (TrialW'(root_in) << (B + 1)) + (TrialW'(1) << (2 * B));
    assign take  = TrialW'(rem_in) >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= take ? (root_in | (RootW'(1) << B)) : root_in;
      end
    end

    // the last stage needs no remainder
    if (k < RootW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= take ? (rem_in - trial[RadW-1:0]) : rem_in;
        end
      end
    end
  end

  assign root_o = root_q[RootW-1];

endmodule

/* src/sgpa_div.sv */
module sgpa_div
  import sgpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NumW-1:0]   num_i,
  input  logic [CubeW-1:0]  den_i,
  output logic [QuotW-1:0]  quot_o,
  output logic              ovf_o
);

  localparam int unsigned CmpW = CubeW + QuotW;

  logic [NumW-1:0]  rem_q  [QuotW];
  logic [CubeW-1:0] den_q  [QuotW];
  logic [QuotW-1:0] quot_q [QuotW+1];
  logic             ovf_q  [QuotW+1];

  // quotient of 2^QuotW or more is flagged up front
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i;
      den_q[0]  <= den_i;
      quot_q[0] <= '0;
      ovf_q[0]  <= CmpW'(num_i) >= (CmpW'(den_i) << QuotW);
    end
  end

  // restoring long division, one quotient bit per stage
  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    localparam int unsigned I = QuotW - 1 - k;
    logic [CmpW-1:0] shifted;
    logic            take;

    assign shifted = CmpW'(den_q[k]) << I;
    assign take    = CmpW'(rem_q[k]) >= shifted;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quot_q[k+1] <= take ? (quot_q[k] | (QuotW'(1) << I)) : quot_q[k];
        ovf_q[k+1]  <= ovf_q[k];
      end
    end

    // remainder and divisor are not needed after the last stage
    if (k < QuotW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= take ? (rem_q[k] - shifted[NumW-1:0]) : rem_q[k];
          den_q[k+1] <= den_q[k];
        end
      end
    end
  end

  assign quot_o = quot_q[QuotW];
  assign ovf_o  = ovf_q[QuotW];

endmodule

/* src/softened_gravity_pair_accel.sv */
// channel  direction  handshake              payload
// in       input      in_valid_i/in_stall_o   in_data_i  (in_t)
// out      output     out_valid_o/out_stall_i out_data_o (out_t)
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one transaction enters per cycle while the output is not stalled; results leave in order
// most of the pipeline depth comes from the 35-stage square root and the 34-stage divider
// asynchronous active-low reset clears valid bits and loads register defaults
// a stalled output holding a valid result freezes the whole pipeline; nothing is dropped or repeated
module softened_gravity_pair_accel
  import sgpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned NumStages = 3 + SqrtLat + 3 + DivLat + 1;
  localparam int unsigned PosLat    = 3 + DivLat;

  typedef struct packed {
    logic [32:0] ax;
    logic [32:0] ay;
    logic [63:0] gm;
    logic        posx;
    logic        posy;
  } side_t;

  logic        en;
  logic [NumStages-1:0] v_q;
  logic [31:0] gravity_q, mindist_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= GravityReset;
      mindist_q <= MinDistReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegGravity: gravity_q <= cfg_data_i;
        RegMinDist: mindist_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: hold everything while a result waits
  assign en         = !(v_q[NumStages-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NumStages-2:0], in_valid_i};
    end
  end

  // stage a: differences and magnitudes
  logic signed [32:0] dx, dy;
  logic [32:0] ax_q, ay_q;
  logic        posx_q, posy_q;
  logic [31:0] mass_q;

  assign dx = {in_data_i.target_x[31], in_data_i.target_x}
            - {in_data_i.source_x[31], in_data_i.source_x};
  assign dy = {in_data_i.target_y[31], in_data_i.target_y}
            - {in_data_i.source_y[31], in_data_i.source_y};

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q   <= dx[32] ? 33'(-dx) : 33'(dx);
      ay_q   <= dy[32] ? 33'(-dy) : 33'(dy);
      posx_q <= !dx[32] && (dx != '0);
      posy_q <= !dy[32] && (dy != '0);
      mass_q <= in_data_i.source_mass;
    end
  end

  // stage b: squares and G*m
  logic [65:0] sqx_q, sqy_q;
  logic [63:0] gm_b_q;
  logic [32:0] ax_b_q, ay_b_q;
  logic        posx_b_q, posy_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q    <= 66'(ax_q) * 66'(ax_q);
      sqy_q    <= 66'(ay_q) * 66'(ay_q);
      gm_b_q   <= 64'(gravity_q) * 64'(mass_q);
      ax_b_q   <= ax_q;
      ay_b_q   <= ay_q;
      posx_b_q <= posx_q;
      posy_b_q <= posy_q;
    end
  end

  // stage c: squared distance
  logic [RadW-1:0] sq_q;
  side_t           side_c_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q     <= RadW'(sqx_q) + RadW'(sqy_q);
      side_c_q <= '{ax: ax_b_q, ay: ay_b_q, gm: gm_b_q, posx: posx_b_q, posy: posy_b_q};
    end
  end

  // square root with side data kept in step
  logic [RootW-1:0] root;
  side_t            sd_q [SqrtLat];

  sgpa_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sq_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= side_c_q;
      for (int k = 1; k < SqrtLat; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  // stage e: clamp distance, square it, numerator partial products
  side_t            sr;
  logic [RootW-1:0] dmin, dclamp;
  logic [RootW-1:0] d_q;
  logic [69:0]      d2_q;
  logic [64:0]      nxl_q, nxh_q, nyl_q, nyh_q;

  assign sr     = sd_q[SqrtLat-1];
  assign dmin   = (mindist_q == '0) ? RootW'(1) : RootW'(mindist_q);
  assign dclamp = (root > dmin) ? root : dmin;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q   <= dclamp;
      d2_q  <= 70'(dclamp) * 70'(dclamp);
      nxl_q <= 65'(sr.gm[31:0]) * 65'(sr.ax);
      nxh_q <= 65'(sr.gm[63:32]) * 65'(sr.ax);
      nyl_q <= 65'(sr.gm[31:0]) * 65'(sr.ay);
      nyh_q <= 65'(sr.gm[63:32]) * 65'(sr.ay);
    end
  end

  // stage f: cube partial products, numerator sums
  logic [69:0]     clo_q, chi_q;
  logic [NumW-1:0] numx_f_q, numy_f_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      clo_q    <= 70'(d2_q[34:0]) * 70'(d_q);
      chi_q    <= 70'(d2_q[69:35]) * 70'(d_q);
      numx_f_q <= (NumW'(nxl_q) + (NumW'(nxh_q) << 32)) << 16;
      numy_f_q <= (NumW'(nyl_q) + (NumW'(nyh_q) << 32)) << 16;
    end
  end

  // stage g: cube
  logic [CubeW-1:0] cube_q;
  logic [NumW-1:0]  numx_q, numy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cube_q <= CubeW'(clo_q) + (CubeW'(chi_q) << 35);
      numx_q <= numx_f_q;
      numy_q <= numy_f_q;
    end
  end

  // sign bits ride alongside clamp, cube and divide
  logic [1:0] pd_q [PosLat];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pd_q[0] <= {sr.posx, sr.posy};
      for (int k = 1; k < PosLat; k++) begin
        pd_q[k] <= pd_q[k-1];
      end
    end
  end

  // dividers, one per component
  logic [QuotW-1:0] qx, qy;
  logic             ovx, ovy;

  sgpa_div u_div_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (numx_q),
    .den_i  (cube_q),
    .quot_o (qx),
    .ovf_o  (ovx)
  );

  sgpa_div u_div_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (numy_q),
    .den_i  (cube_q),
    .quot_o (qy),
    .ovf_o  (ovy)
  );

  // saturation and sign, output register
  logic             px, py, clipx, clipy;
  logic [QuotW-1:0] limx, limy, mx, my;
  out_t             out_q;

  assign px    = pd_q[PosLat-1][1];
  assign py    = pd_q[PosLat-1][0];
  assign limx  = px ? QuotW'(33'h080000000) : QuotW'(33'h07FFFFFFF);
  assign limy  = py ? QuotW'(33'h080000000) : QuotW'(33'h07FFFFFFF);
  assign clipx = ovx || (qx > limx);
  assign clipy = ovy || (qy > limy);
  assign mx    = clipx ? limx : qx;
  assign my    = clipy ? limy : qy;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.accel_x   <= px ? -$signed(mx[31:0]) : $signed(mx[31:0]);
      out_q.accel_y   <= py ? -$signed(my[31:0]) : $signed(my[31:0]);
      out_q.saturated <= clipx || clipy;
    end
  end

  assign out_valid_o = v_q[NumStages-1];
  assign out_data_o  = out_q;

endmodule

/* tb/sv/tb_softened_gravity_pair_accel.sv */
`timescale 1ns / 1ps

module tb_softened_gravity_pair_accel;
  import sgpa_pkg::*;

  localparam int unsigned Latency = 76;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  softened_gravity_pair_accel DUT (.*);

  // clock
  always #4 clk_i = ~clk_i;

  // predictor copy of the registers
  logic [31:0] grav_q = GravityReset;
  logic [31:0] dmin_q = MinDistReset;

  in_t  pair_q[$];
  out_t accel_exp_q[$];
  int   fail_cnt = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_cycles = 0;

  // one component magnitude with sign and clipping
  function automatic logic [31:0] accel_component(logic [63:0] gm, logic signed [32:0] delta,
                                                  logic [104:0] cube, ref logic clip);
    logic [32:0]  ad;
    logic [127:0] num;
    logic [127:0] quo;
    logic [31:0]  limit;
    logic [31:0]  m;
    ad = delta[32] ? 33'(-delta) : 33'(delta);
    if (ad == 0 || gm == 0) return 32'd0;
    num = (128'(gm) * 128'(ad)) << 16;
    quo = num / 128'(cube);
    limit = (delta > 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (quo > 128'(limit)) begin
      clip = 1'b1;
      m = limit;
    end else begin
      m = quo[31:0];
    end
    return (delta > 0) ? -m : m;
  endfunction

  // full pair acceleration
  function automatic out_t pair_accel(in_t p);
    logic signed [32:0] dx, dy;
    logic [32:0]  ax, ay;
    logic [66:0]  sq;
    logic [34:0]  root, cand;
    logic [34:0]  d;
    logic [104:0] cube;
    logic [63:0]  gm;
    logic         clip;
    out_t         r;
    dx = 33'(p.target_x) - 33'(p.source_x);
    dy = 33'(p.target_y) - 33'(p.source_y);
    ax = dx[32] ? 33'(-dx) : 33'(dx);
    ay = dy[32] ? 33'(-dy) : 33'(dy);
    sq = 67'(ax) * 67'(ax) + 67'(ay) * 67'(ay);
    root = '0;
    for (int b = 34; b >= 0; b--) begin
      cand = root | (35'd1 << b);
      if (70'(sq) >= 70'(cand) * 70'(cand)) root = cand;
    end
    d = (dmin_q == 0) ? 35'd1 : 35'(dmin_q);
    if (root > d) d = root;
    cube = 105'(d) * 105'(d) * 105'(d);
    gm = 64'(grav_q) * 64'(p.source_mass);
    clip = 1'b0;
    r.accel_x = accel_component(gm, dx, cube, clip);
    r.accel_y = accel_component(gm, dy, cube, clip);
    r.saturated = clip;
    return r;
  endfunction

  // driver: offers pending pairs, predicts on acceptance
  logic acc_in = 1'b0;
  always @(posedge clk_i) begin
    acc_in <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      accel_exp_q = {accel_exp_q, pair_accel(in_data_i)};
      void'(pair_q.pop_front());
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !acc_in) begin
      // hold the stalled payload
    end else if (pair_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_valid_i <= 1'b1;
      in_data_i <= pair_q[0];
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver stall pattern, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (accel_exp_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        fail_cnt++;
      end else begin
        e = accel_exp_q.pop_front();
        if (out_data_o.accel_x !== e.accel_x) begin
          $display("%0t: accel_x expected %h actual %h", $time, e.accel_x, out_data_o.accel_x);
          fail_cnt++;
        end
        if (out_data_o.accel_y !== e.accel_y) begin
          $display("%0t: accel_y expected %h actual %h", $time, e.accel_y, out_data_o.accel_y);
          fail_cnt++;
        end
        if (out_data_o.saturated !== e.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, e.saturated,
                   out_data_o.saturated);
          fail_cnt++;
        end
      end
    end
  end

  // register write, only while idle
  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == RegGravity) grav_q = val;
    else if (idx == RegMinDist) dmin_q = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pair_q.size() > 0 || accel_exp_q.size() > 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed(16'($urandom())));
      2: return {$urandom_range(1) ? 8'hFF : 8'h00, 24'($urandom())};
      default: return 32'($signed(20'($urandom()))) << 4;
    endcase
  endfunction

  task automatic add_random(int n);
    in_t p;
    int  m;
    repeat (n) begin
      m = $urandom_range(3);
      p.target_x = rand_word(m);
      p.target_y = rand_word(m);
      if ($urandom_range(9) == 0) begin
        p.source_x = p.target_x;
        p.source_y = p.target_y;
      end else begin
        p.source_x = p.target_x + rand_word($urandom_range(3));
        p.source_y = p.target_y + rand_word($urandom_range(3));
      end
      p.source_mass = $urandom_range(3) == 0 ? $urandom() : 32'($urandom_range(32'h000F_FFFF));
      pair_q = {pair_q, p};
    end
  endtask

  // directed pairs: extremes, coincident, clipping
  task automatic add_directed();
    in_t p;
    logic [31:0] ext[5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF};
    foreach (ext[i]) begin
      p.target_x = ext[i];
      p.target_y = ext[4 - i];
      p.source_x = ext[(i + 1) % 5];
      p.source_y = ext[(i + 3) % 5];
      p.source_mass = ext[(i + 2) % 5];
      pair_q = {pair_q, p};
    end
    p = '{32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000};
    pair_q = {pair_q, p};
    p = '{32'h0, 32'h0, 32'h0, 32'h1, 32'hFFFF_FFFF};
    pair_q = {pair_q, p};
    p = '{32'h0, 32'h1, 32'h0, 32'h0, 32'hFFFF_FFFF};
    pair_q = {pair_q, p};
    p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF};
    pair_q = {pair_q, p};
    p = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    pair_q = {pair_q, p};
    p = '{32'h0002_0000, 32'hFFFE_0000, 32'h0, 32'h0, 32'h0010_0000};
    pair_q = {pair_q, p};
  endtask

  // stimulus
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    add_directed();
    drain();

    write_reg(RegGravity, 32'hFFFF_FFFF);
    write_reg(RegMinDist, 32'h0);
    add_directed();
    add_random(150);
    drain();

    write_reg(RegGravity, 32'h0);
    write_reg(RegMinDist, 32'hFFFF_FFFF);
    add_directed();
    add_random(100);
    drain();

    write_reg(RegGravity, 32'h0001_0000);
    write_reg(RegMinDist, 32'd52429);
    send_idle_pct = 78;
    add_random(250);
    drain();

    send_idle_pct = 0;
    stall_pct = 78;
    write_reg(RegGravity, $urandom());
    write_reg(RegMinDist, 32'd1);
    add_random(250);
    drain();

    send_idle_pct = 23;
    stall_pct = 23;
    write_reg(RegGravity, $urandom_range(32'h0010_0000));
    write_reg(RegMinDist, $urandom_range(1, 32'h0004_0000));
    add_random(250);
    drain();

    // long receiver hold-off with the sender pushing
    send_idle_pct = 0;
    stall_pct = 0;
    @(negedge clk_i);
    hold_cycles = 300;
    add_random(250);
    drain();

    if (fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // timeout
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
